// ===== rtl/pbr_pkg.sv =====
// ----------------------------------------------------------------------------
// pbr_pkg: shared types and constants of the pulse beat rate detector
// Field widths, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pbr_pkg;

    localparam int SAMPLE_W = 18;
    localparam int TIME_W   = 32;
    localparam int RATE_W   = 16;
    localparam int OFS_W    = 12;
    localparam int IVL_W    = 16;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 3;

    // stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 18'h3FFFF;
    localparam logic [RATE_W-1:0]   MS_PER_MIN = 16'd60000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FINGER_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_OFS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RISE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_IVL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_IVL    = 3'd4;

    // register reset values
    localparam logic [SAMPLE_W-1:0] RST_FINGER_THR = 18'd30000;
    localparam logic [OFS_W-1:0]    RST_PEAK_OFS   = 12'd40;
    localparam logic [OFS_W-1:0]    RST_MIN_RISE   = 12'd18;
    localparam logic [IVL_W-1:0]    RST_MIN_IVL    = 16'd300;
    localparam logic [IVL_W-1:0]    RST_MAX_IVL    = 16'd3000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_CHECK,
        ST_RATE_WAIT,
        ST_TOT_GO,
        ST_TOT_WAIT,
        ST_OUT
    } state_t;

    function automatic logic is_rail(input logic [SAMPLE_W-1:0] v);
        return (v == '0) || (v == FULL_SCALE);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pbr_ram.sv =====
// ----------------------------------------------------------------------------
// pbr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pbr_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 20
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pbr_div.sv =====
// ----------------------------------------------------------------------------
// pbr_div: shared restoring divider
// One quotient bit per cycle; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module pbr_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;
    logic             qbit;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign qbit      = rem_shift >= {1'b0, den_reg};

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            num_next = {num_reg[NUM_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

`default_nettype wire

// ===== rtl/pulse_beat_rate_detector.sv =====
// ----------------------------------------------------------------------------
// pulse_beat_rate_detector: optical pulse beat and heart rate detector
//
// Input stream (s_*): one transfer carries a red/infrared sample pair and a
// millisecond timestamp. Output stream (m_*): exactly one transfer per input
// transfer, carrying the beat flag, the smoothed heart rate in bpm and the
// rate-valid flag. Registers are loaded through cfg_wr_en/cfg_index/cfg_data.
//
// The block takes one sample at a time. A single restoring divider
// of DIV_W bits (one quotient bit per cycle) is shared by the window average,
// the 60000/interval conversion and the bpm average. A rail sample goes
// straight to the output; any other sample runs the divider for the window
// average, and a beat with an accepted interval runs it twice more, for the
// rate and the bpm average. s_tready is high only while the sequencer is idle.
//
// The result sits in an output register, so a new sample is accepted while
// it waits; if the receiver stalls, the next result holds in the sequencer
// until the output register is free. Reset clears the sample window (via a
// fill flag), the bpm history, the rate and all flags, and restores the
// register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_beat_rate_detector
    import pbr_pkg::*;
#(
    parameter int AVG_WINDOW = 20,
    parameter int BPM_TAPS   = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // red_sample[17:0], ir_sample[35:18], time_ms[67:36], zero pad[71:68]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // beat[0], heart_rate[16:1], rate_valid[17], zero pad[23:18]
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int HIST_AW = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int SLOT_W  = (BPM_TAPS > 1) ? $clog2(BPM_TAPS) : 1;
    localparam int SUM_W   = SAMPLE_W + $clog2(AVG_WINDOW);
    localparam int TOT_W   = RATE_W + $clog2(BPM_TAPS);
    localparam int DIV_W   = (SUM_W > TOT_W) ? SUM_W : TOT_W;
    localparam int DEN_W   = 16;
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(AVG_WINDOW * int'(FULL_SCALE));

    // configuration registers
    logic [SAMPLE_W-1:0] finger_thr_reg;
    logic [OFS_W-1:0]    peak_ofs_reg;
    logic [OFS_W-1:0]    min_rise_reg;
    logic [IVL_W-1:0]    min_ivl_reg;
    logic [IVL_W-1:0]    max_ivl_reg;

    state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [HIST_AW-1:0]  hist_wr_reg, hist_wr_next;
    logic                hist_full_reg, hist_full_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic [SAMPLE_W-1:0] last_chk_reg, last_chk_next;
    logic                above_peak_reg, above_peak_next;
    logic [TIME_W-1:0]   last_beat_reg, last_beat_next;
    logic [RATE_W-1:0]   bpm_hist_reg [BPM_TAPS];
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [TOT_W-1:0]    tot_reg, tot_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic                valid_flag_reg, valid_flag_next;
    logic                beat_reg, beat_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                bpm_we;

    // input fields
    logic [SAMPLE_W-1:0] in_red, in_ir, in_sel;
    logic [TIME_W-1:0]   in_time;
    logic                s_accept;

    // sample window RAM
    logic                ram_we, ram_re;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0] old_smp;

    // beat checks
    logic [SAMPLE_W:0]   peak_thr;
    logic [SAMPLE_W-1:0] rise;
    logic                qualify;
    logic                finger_ok;
    logic [TIME_W-1:0]   delta;
    logic                ivl_ok;
    logic                rate_go;
    logic [RATE_W-1:0]   old_bpm;

    // shared divider
    logic                div_start;
    logic [DIV_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic                div_done;
    logic [DIV_W-1:0]    div_quot;

    assign in_red   = s_tdata[17:0];
    assign in_ir    = s_tdata[35:18];
    assign in_time  = s_tdata[67:36];
    assign in_sel   = (is_rail(in_ir) && !is_rail(in_red)) ? in_red : in_ir;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign ram_re   = s_accept;
    assign ram_we   = (state_reg == ST_CHECK);
    // entries not yet written since reset read as zero
    assign old_smp  = hist_full_reg ? ram_rdata : '0;

    assign peak_thr  = {1'b0, avg_reg} + (SAMPLE_W+1)'(peak_ofs_reg);
    assign rise      = (smp_reg > last_chk_reg) ? (smp_reg - last_chk_reg) : '0;
    assign qualify   = ({1'b0, smp_reg} > peak_thr) && (rise > SAMPLE_W'(min_rise_reg));
    assign finger_ok = (smp_reg >= finger_thr_reg);
    assign delta     = now_reg - last_beat_reg;
    assign ivl_ok    = (delta > TIME_W'(min_ivl_reg)) && (delta < TIME_W'(max_ivl_reg));
    assign rate_go   = finger_ok && qualify && !above_peak_reg &&
                       (last_beat_reg != '0) && ivl_ok;
    assign old_bpm   = bpm_hist_reg[slot_reg];
    assign bpm_we    = (state_reg == ST_RATE_WAIT) && div_done;

    pbr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (AVG_WINDOW)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (hist_wr_reg),
        .wdata (smp_reg),
        .re    (ram_re),
        .raddr (hist_wr_reg),
        .rdata (ram_rdata)
    );

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_num   = DIV_W'(sum_reg);
        div_den   = DEN_W'(AVG_WINDOW);
        case (state_reg)
            ST_AVG_GO: begin
                div_start = 1'b1;
            end
            ST_CHECK: begin
                div_start = rate_go;
                div_num   = DIV_W'(MS_PER_MIN);
                div_den   = delta[DEN_W-1:0];
            end
            ST_TOT_GO: begin
                div_start = 1'b1;
                div_num   = DIV_W'(tot_reg);
                div_den   = DEN_W'(BPM_TAPS);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    pbr_div #(
        .NUM_W (DIV_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quot)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        smp_next        = smp_reg;
        now_next        = now_reg;
        hist_wr_next    = hist_wr_reg;
        hist_full_next  = hist_full_reg;
        sum_next        = sum_reg;
        avg_next        = avg_reg;
        last_chk_next   = last_chk_reg;
        above_peak_next = above_peak_reg;
        last_beat_next  = last_beat_reg;
        slot_next       = slot_reg;
        tot_next        = tot_reg;
        rate_next       = rate_reg;
        valid_flag_next = valid_flag_reg;
        beat_next       = beat_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    smp_next  = in_sel;
                    now_next  = in_time;
                    beat_next = 1'b0;
                    if (is_rail(in_sel)) begin
                        valid_flag_next = 1'b0;
                        state_next      = ST_OUT;
                    end else begin
                        state_next = ST_AVG_GO;
                    end
                end
            end
            ST_AVG_GO: begin
                state_next = ST_AVG_WAIT;
            end
            ST_AVG_WAIT: begin
                if (div_done) begin
                    avg_next   = div_quot[SAMPLE_W-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // push the sample into the window and keep the running sum
                sum_next = sum_reg - SUM_W'(old_smp) + SUM_W'(smp_reg);
                if (hist_wr_reg == HIST_AW'(AVG_WINDOW - 1)) begin
                    hist_wr_next   = '0;
                    hist_full_next = 1'b1;
                end else begin
                    hist_wr_next = hist_wr_reg + 1'b1;
                end
                state_next = ST_OUT;
                if (!finger_ok) begin
                    valid_flag_next = 1'b0;
                end else begin
                    last_chk_next = smp_reg;
                    if (qualify) begin
                        above_peak_next = 1'b1;
                        if (!above_peak_reg) begin
                            beat_next      = 1'b1;
                            last_beat_next = now_reg;
                            if (rate_go) begin
                                state_next = ST_RATE_WAIT;
                            end
                        end
                    end else begin
                        above_peak_next = 1'b0;
                    end
                end
            end
            ST_RATE_WAIT: begin
                if (div_done) begin
                    tot_next = tot_reg - TOT_W'(old_bpm) + TOT_W'(div_quot[RATE_W-1:0]);
                    if (slot_reg == SLOT_W'(BPM_TAPS - 1)) begin
                        slot_next = '0;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                    end
                    state_next = ST_TOT_GO;
                end
            end
            ST_TOT_GO: begin
                state_next = ST_TOT_WAIT;
            end
            ST_TOT_WAIT: begin
                if (div_done) begin
                    rate_next       = div_quot[RATE_W-1:0];
                    valid_flag_next = 1'b1;
                    state_next      = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, valid_flag_reg, rate_reg, beat_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hist_wr_reg    <= '0;
            hist_full_reg  <= 1'b0;
            sum_reg        <= '0;
            last_chk_reg   <= '0;
            above_peak_reg <= 1'b0;
            last_beat_reg  <= '0;
            slot_reg       <= '0;
            tot_reg        <= '0;
            rate_reg       <= '0;
            valid_flag_reg <= 1'b0;
            beat_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hist_wr_reg    <= hist_wr_next;
            hist_full_reg  <= hist_full_next;
            sum_reg        <= sum_next;
            last_chk_reg   <= last_chk_next;
            above_peak_reg <= above_peak_next;
            last_beat_reg  <= last_beat_next;
            slot_reg       <= slot_next;
            tot_reg        <= tot_next;
            rate_reg       <= rate_next;
            valid_flag_reg <= valid_flag_next;
            beat_reg       <= beat_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        smp_reg     <= smp_next;
        now_reg     <= now_next;
        avg_reg     <= avg_next;
        m_tdata_reg <= m_tdata_next;
    end

    // bpm history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BPM_TAPS; i++) begin
                bpm_hist_reg[i] <= '0;
            end
        end else if (bpm_we) begin
            bpm_hist_reg[slot_reg] <= div_quot[RATE_W-1:0];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finger_thr_reg <= RST_FINGER_THR;
            peak_ofs_reg   <= RST_PEAK_OFS;
            min_rise_reg   <= RST_MIN_RISE;
            min_ivl_reg    <= RST_MIN_IVL;
            max_ivl_reg    <= RST_MAX_IVL;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FINGER_THR: finger_thr_reg <= cfg_data[SAMPLE_W-1:0];
                REG_PEAK_OFS:   peak_ofs_reg   <= cfg_data[OFS_W-1:0];
                REG_MIN_RISE:   min_rise_reg   <= cfg_data[OFS_W-1:0];
                REG_MIN_IVL:    min_ivl_reg    <= cfg_data[IVL_W-1:0];
                REG_MAX_IVL:    max_ivl_reg    <= cfg_data[IVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("sample accepted while another is in progress");

    a_fill_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_full_reg |=> hist_full_reg)
        else $error("window fill flag dropped");

    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_wr_reg <= HIST_AW'(AVG_WINDOW - 1))
        else $error("window write pointer out of range");

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= SUM_MAX)
        else $error("running window sum exceeds its bound");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(valid_flag_reg) |-> ($past(state_reg) == ST_TOT_WAIT))
        else $error("rate valid set outside the rate update");

endmodule

`default_nettype wire

// ===== tb/pulse_beat_rate_detector_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pulse_beat_rate_detector_tb: self-checking bench for the pulse beat detector
// Streams synthetic pulse waveforms, rail and noise samples through the block
// under several register settings and idle patterns. A local tracker of the
// window average, beat detection and bpm smoothing predicts every result,
// and each result transfer is checked field by field in arrival order.
// ----------------------------------------------------------------------------

module pulse_beat_rate_detector_tb;
    import pbr_pkg::*;

    localparam int AVG_WINDOW = 20;
    localparam int BPM_TAPS   = 4;

    typedef struct {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] ir;
        logic [TIME_W-1:0]   t;
    } pulse_smp_t;

    typedef struct {
        logic              beat;
        logic [RATE_W-1:0] rate;
        logic              valid;
    } beat_res_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    pulse_smp_t  sample_q[$];    // samples waiting to be sent
    beat_res_t   beat_res_q[$];  // predicted results, oldest first
    beat_res_t   want;
    logic        in_took = 1'b0;
    int unsigned mismatch_cnt = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int unsigned rx_stall_req = 0;
    int unsigned rx_stall_left = 0;

    // tracker copy of the registers
    logic [SAMPLE_W-1:0] thr_m     = RST_FINGER_THR;
    logic [OFS_W-1:0]    ofs_m     = RST_PEAK_OFS;
    logic [OFS_W-1:0]    rise_m    = RST_MIN_RISE;
    logic [IVL_W-1:0]    min_ivl_m = RST_MIN_IVL;
    logic [IVL_W-1:0]    max_ivl_m = RST_MAX_IVL;

    // tracker copy of the state
    logic [SAMPLE_W-1:0] win_m [AVG_WINDOW] = '{default: '0};
    int unsigned         win_wr_m    = 0;
    logic [SAMPLE_W-1:0] last_m      = '0;
    logic                peak_m      = 1'b0;
    logic [TIME_W-1:0]   last_beat_m = '0;
    logic [RATE_W-1:0]   bpm_m [BPM_TAPS] = '{default: '0};
    int unsigned         slot_m      = 0;
    logic [RATE_W-1:0]   rate_m      = '0;
    logic                vld_m       = 1'b0;

    pulse_beat_rate_detector #(
        .AVG_WINDOW(AVG_WINDOW),
        .BPM_TAPS  (BPM_TAPS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic logic on_rail(input logic [SAMPLE_W-1:0] v);
        return (v == '0) || (v == FULL_SCALE);
    endfunction

    // Advance the tracker by one sample and return the result it implies.
    function automatic beat_res_t track_pulse(input logic [SAMPLE_W-1:0] red,
                                              input logic [SAMPLE_W-1:0] ir,
                                              input logic [TIME_W-1:0]   now);
        logic [SAMPLE_W-1:0] s;
        logic [31:0]         sum;
        logic [31:0]         avg;
        logic [31:0]         rise;
        logic [31:0]         delta;
        logic [31:0]         tot;
        beat_res_t           r;
        s = ir;
        r.beat = 1'b0;
        if (on_rail(ir) && !on_rail(red)) s = red;
        if (on_rail(s)) begin
            vld_m = 1'b0;
        end else begin
            sum = '0;
            for (int i = 0; i < AVG_WINDOW; i++) sum = sum + win_m[i];
            avg = sum / AVG_WINDOW;
            win_m[win_wr_m] = s;
            win_wr_m = (win_wr_m + 1) % AVG_WINDOW;
            if (s < thr_m) begin
                vld_m = 1'b0;
            end else begin
                rise = (s > last_m) ? 32'(s) - 32'(last_m) : 32'd0;
                if (32'(s) > avg + 32'(ofs_m) && rise > 32'(rise_m)) begin
                    if (!peak_m) begin
                        peak_m = 1'b1;
                        r.beat = 1'b1;
                    end
                end else begin
                    peak_m = 1'b0;
                end
                last_m = s;
                if (r.beat) begin
                    // a zero timestamp stands for no beat seen yet
                    if (last_beat_m != '0) begin
                        delta = now - last_beat_m;
                        if (delta > 32'(min_ivl_m) && delta < 32'(max_ivl_m)) begin
                            bpm_m[slot_m] = RATE_W'(32'd60000 / delta);
                            slot_m = (slot_m + 1) % BPM_TAPS;
                            tot = '0;
                            for (int i = 0; i < BPM_TAPS; i++) tot = tot + bpm_m[i];
                            rate_m = RATE_W'(tot / BPM_TAPS);
                            vld_m = 1'b1;
                        end
                    end
                    last_beat_m = now;
                end
            end
        end
        r.rate  = rate_m;
        r.valid = vld_m;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (mismatch_cnt < 50)
            $display("mismatch %0s: expected %0h got %0h at %0t", what, exp_v, got_v,
                     $realtime);
        mismatch_cnt++;
    endtask

    task automatic push_sample(input int unsigned red, input int unsigned ir,
                               input int unsigned t);
        pulse_smp_t p;
        p.red = red[SAMPLE_W-1:0];
        p.ir  = ir[SAMPLE_W-1:0];
        p.t   = t;
        sample_q.push_back(p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val[CFG_W-1:0];
        case (idx)
            REG_FINGER_THR: thr_m     = val[SAMPLE_W-1:0];
            REG_PEAK_OFS:   ofs_m     = val[OFS_W-1:0];
            REG_MIN_RISE:   rise_m    = val[OFS_W-1:0];
            REG_MIN_IVL:    min_ivl_m = val[IVL_W-1:0];
            REG_MAX_IVL:    max_ivl_m = val[IVL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || beat_res_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Monitor: predict on every sample transfer, check every result transfer.
    always @(posedge aclk) begin
        in_took = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (beat_res_q.size() == 0) begin
                    flag_mismatch("unexpected result", '0, 32'(m_tdata));
                end else begin
                    want = beat_res_q.pop_front();
                    if (m_tdata[0] !== want.beat)
                        flag_mismatch("beat", 32'(want.beat), 32'(m_tdata[0]));
                    if (m_tdata[16:1] !== want.rate)
                        flag_mismatch("heart_rate", 32'(want.rate), 32'(m_tdata[16:1]));
                    if (m_tdata[17] !== want.valid)
                        flag_mismatch("rate_valid", 32'(want.valid), 32'(m_tdata[17]));
                end
            end
            if (s_tvalid && s_tready) begin
                beat_res_q.push_back(track_pulse(s_tdata[17:0], s_tdata[35:18],
                                                 s_tdata[67:36]));
                in_took = 1'b1;
            end
        end
    end

    // Driver: hold an offered sample until its transfer, then maybe idle.
    always @(negedge aclk) begin
        if (in_took) void'(sample_q.pop_front());
        if (!s_tvalid || in_took) begin
            if (aresetn && sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, sample_q[0].t, sample_q[0].ir, sample_q[0].red};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (rx_stall_req != 0) begin
            rx_stall_left = rx_stall_req;
            rx_stall_req  = 0;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            rx_stall_left = rx_stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        int unsigned n_items [5] = '{40, 30, 15, 40, 10};
        int unsigned kind;
        int unsigned c;
        int unsigned v;
        int unsigned wv_t;
        int unsigned wv_base;
        int unsigned wv_amp;
        int unsigned wv_phase;
        int unsigned wv_period;
        bit          wv_twostep;
        wv_t       = 32'd6000;
        wv_amp     = 20000;
        wv_phase   = 0;
        wv_period  = 20;
        wv_twostep = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        tx_idle_pct = 24;
        rx_idle_pct = 81;

        // directed: channel choice, rails, no finger, held peak, limits, wrap
        push_sample(50000, 0, 0);
        push_sample(50000, FULL_SCALE, 40);
        push_sample(0, 0, 80);
        push_sample(FULL_SCALE, FULL_SCALE, 100);
        push_sample(FULL_SCALE, 60000, 120);
        push_sample(0, 70000, 160);
        push_sample(12345, 1000, 200);
        push_sample(12345, 62000, 240);
        push_sample(12345, 90000, 900);
        push_sample(12345, 91000, 940);
        push_sample(12345, 85000, 980);
        push_sample(12345, 95000, 1100);
        push_sample(12345, 85000, 1140);
        push_sample(12345, 99000, 2000);
        push_sample(12345, 85000, 2040);
        push_sample(12345, 105000, 5200);
        push_sample(12345, 85000, 5240);
        push_sample(12345, 110000, 32'hFFFF_FE00);
        push_sample(12345, 85000, 32'hFFFF_FE40);
        push_sample(12345, 120000, 32'h0000_0100);
        push_sample(262142, 262142, 32'hFFFF_FFFF);
        push_sample(1, 1, 1);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 24; rx_idle_pct = 81; end
                1: begin tx_idle_pct = 81; rx_idle_pct = 24; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int cs = 0; cs < 5; cs++) begin
                case (cs)
                    0: begin
                        write_reg(REG_FINGER_THR, RST_FINGER_THR);
                        write_reg(REG_PEAK_OFS, RST_PEAK_OFS);
                        write_reg(REG_MIN_RISE, RST_MIN_RISE);
                        write_reg(REG_MIN_IVL, RST_MIN_IVL);
                        write_reg(REG_MAX_IVL, RST_MAX_IVL);
                    end
                    1: begin
                        write_reg(REG_FINGER_THR, 0);
                        write_reg(REG_PEAK_OFS, 0);
                        write_reg(REG_MIN_RISE, 0);
                        write_reg(REG_MIN_IVL, 1);
                        write_reg(REG_MAX_IVL, 65535);
                    end
                    2: begin
                        write_reg(REG_FINGER_THR, 262143);
                        write_reg(REG_PEAK_OFS, 4095);
                        write_reg(REG_MIN_RISE, 4095);
                        write_reg(REG_MIN_IVL, 65535);
                        write_reg(REG_MAX_IVL, 1);
                        write_reg(CFG_IDX_W'(7), 32'h3FFFF);
                    end
                    3: begin
                        // junk above the width of the offset, rise and interval registers must be dropped
                        write_reg(REG_FINGER_THR, $urandom_range(20000, 90000));
                        write_reg(REG_PEAK_OFS,
                                  ($urandom & 32'h3F000) | $urandom_range(0, 200));
                        write_reg(REG_MIN_RISE,
                                  ($urandom & 32'h3F000) | $urandom_range(0, 100));
                        write_reg(REG_MIN_IVL,
                                  ($urandom & 32'h30000) | $urandom_range(200, 500));
                        write_reg(REG_MAX_IVL,
                                  ($urandom & 32'h30000) | $urandom_range(1500, 4000));
                        write_reg(CFG_IDX_W'(5), $urandom);
                        write_reg(CFG_IDX_W'(6), $urandom);
                    end
                    default: begin
                        // equal limits: no interval can be accepted
                        v = $urandom_range(300, 3000);
                        write_reg(REG_FINGER_THR, 20000);
                        write_reg(REG_MIN_IVL, v);
                        write_reg(REG_MAX_IVL, v);
                    end
                endcase
                @(posedge aclk);
                if (ph == 0 && cs == 0) rx_stall_req = 400;
                wv_base = $urandom_range(20000, 150000);
                repeat (n_items[cs]) begin
                    kind = $urandom_range(99);
                    wv_t = wv_t + $urandom_range(10, 60);
                    if ($urandom_range(59) == 0) wv_t = 32'hFFFF_FFFF - $urandom_range(0, 1500);
                    if (kind < 75) begin
                        // pulse shape: sharp rise, optionally in two steps, then decay
                        if (wv_phase == 0)
                            v = wv_twostep ? wv_base + wv_amp / 2 : wv_base + wv_amp;
                        else if (wv_phase == 1 && wv_twostep)
                            v = wv_base + wv_amp;
                        else
                            v = wv_base + (wv_amp >> wv_phase) + $urandom_range(0, 30);
                        wv_phase++;
                        if (wv_phase >= wv_period) begin
                            wv_phase   = 0;
                            wv_period  = $urandom_range(6, 30);
                            wv_amp     = $urandom_range(100, 40000);
                            wv_twostep = ($urandom_range(3) == 0);
                        end
                        c = $urandom_range(9);
                        if (c < 7)
                            push_sample($urandom_range(1, 262142), v, wv_t);
                        else if (c == 7)
                            push_sample(v, 0, wv_t);
                        else if (c == 8)
                            push_sample(v, FULL_SCALE, wv_t);
                        else
                            push_sample(($urandom_range(1) != 0) ? FULL_SCALE : 0, v, wv_t);
                    end else if (kind < 85) begin
                        push_sample($urandom, $urandom, $urandom);
                    end else if (kind < 93) begin
                        push_sample(($urandom_range(1) != 0) ? FULL_SCALE : 0,
                                    ($urandom_range(1) != 0) ? FULL_SCALE : 0, wv_t);
                    end else begin
                        push_sample($urandom, $urandom_range(1, 2000), wv_t);
                    end
                end
                wait_drained();
            end
        end

        repeat (100) @(posedge aclk);
        if (beat_res_q.size() != 0) flag_mismatch("missing results", 0, beat_res_q.size());
        if (mismatch_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
